@@ design/rcc_pkg.sv @@
// Shared types, constants and the per-channel kernel function of the 3x3 convolution core.
`timescale 1ns / 1ps

package rcc_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int IMG_W_BITS    = 12;
    localparam int IMG_H_BITS    = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int PIX_W         = 24;
    localparam int CH_W          = 8;
    localparam int SUM_W         = 15;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_LVL_W       = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RST = 13'd480;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // weights scaled by 4, indexed [column offset][row offset]
    localparam logic signed [SUM_W-1:0] KERN4 [3][3] = '{
        '{ 15'sd4,  15'sd8, -15'sd4},
        '{ 15'sd8,  15'sd1, -15'sd8},
        '{ 15'sd4, -15'sd8, -15'sd4}
    };

    // window[column][row], column 0 oldest, row 0 oldest; pixel is {blue, green, red}
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

    typedef struct packed {
        t_window win;
        logic    last;
    } t_win_item;

    function automatic logic [CH_W-1:0] conv_channel(input t_window win, input logic [1:0] ch);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] scaled;
        logic [CH_W-1:0]         px;
        logic [CH_W-1:0]         res;
        acc = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                px  = win[c][r][CH_W*ch +: CH_W];
                acc = acc + $signed({{(SUM_W-CH_W){1'b0}}, px}) * KERN4[c][r];
            end
        end
        scaled = acc >>> 2;
        if (acc < 0) begin
            res = '0;
        end else if (scaled > 15'sd255) begin
            res = 8'hFF;
        end else begin
            res = scaled[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ design/rcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rcc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rcc_front.sv @@
// Front end: config registers, raster counters, line stores and the 3x3 window.
`timescale 1ns / 1ps

module rcc_front #(
    parameter int MAX_WIDTH = rcc_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [rcc_pkg::PIX_W-1:0]        i_pixel,
    input  logic                             i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [rcc_pkg::Q_LVL_W-1:0]      i_q_level,
    output logic                             o_q_push,
    output rcc_pkg::t_win_item               o_q_item
);
    import rcc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [IMG_W_BITS-1:0] r_width;
    logic [IMG_H_BITS-1:0] r_height;
    logic [AW-1:0]         r_col,  n_col;
    logic [ROW_W-1:0]      r_row,  n_row;
    logic [AW-1:0]         w_last;
    logic [ROW_W-1:0]      h_last;
    logic                  accept;
    logic                  cfg_hit;

    logic                  r_s1_valid;
    logic                  r_s1_emit;
    logic                  r_s1_last;
    logic [AW-1:0]         r_s1_col;
    logic [PIX_W-1:0]      r_s1_pix;
    t_window               r_win, n_win;

    logic [2*PIX_W-1:0]    ram_rdata;
    logic [2*PIX_W-1:0]    ram_wdata;

    // last column and last row of the frame, width and height saturated
    always_comb begin
        if (r_width < 12'd3) begin
            w_last = AW'(2);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_last = AW'(MAX_WIDTH - 1);
        end else begin
            w_last = AW'(r_width - 12'd1);
        end
        if (r_height < 13'd3) begin
            h_last = 12'd2;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_W'(r_height - 13'd1);
        end
    end

    // one word in flight in the window stage plus queued words must fit the queue
    assign o_full  = (32'(i_q_level) + 32'(r_s1_valid)) >= Q_DEPTH;
    assign accept  = i_push && !o_full;
    assign cfg_hit = i_cfg_we && (i_cfg_index == REG_IMAGE_WIDTH ||
                                  i_cfg_index == REG_IMAGE_HEIGHT);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (r_col == w_last) begin
                n_col = '0;
                n_row = (r_row == h_last) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= IMAGE_WIDTH_RST;
            r_height   <= IMAGE_HEIGHT_RST;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[IMG_W_BITS-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit <= (r_row >= 12'd2) && (r_col >= AW'(2));
            r_s1_last <= (r_col == w_last) && (r_row == h_last);
            r_s1_col  <= r_col;
            r_s1_pix  <= i_pixel;
        end
        if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // line stores as one word: {older row, newer row}; written back in the cycle after the read
    assign ram_wdata = {ram_rdata[PIX_W-1:0], r_s1_pix};

    rcc_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (ram_wdata),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_win       = r_win;
        n_win[0]    = r_win[1];
        n_win[1]    = r_win[2];
        n_win[2][0] = ram_rdata[2*PIX_W-1:PIX_W];
        n_win[2][1] = ram_rdata[PIX_W-1:0];
        n_win[2][2] = r_s1_pix;
    end

    assign o_q_push      = r_s1_valid && r_s1_emit;
    assign o_q_item.win  = n_win;
    assign o_q_item.last = r_s1_last;

endmodule

@@ design/rcc_queue.sv @@
// Short queue of finished windows between the front end and the kernel stage.
`timescale 1ns / 1ps

module rcc_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  rcc_pkg::t_win_item          i_item,
    input  logic                        i_pop,
    output logic                        o_valid,
    output rcc_pkg::t_win_item          o_item,
    output logic [rcc_pkg::Q_LVL_W-1:0] o_level
);
    import rcc_pkg::*;

    t_win_item            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr;
    logic [Q_PTR_W-1:0]   r_rptr;
    logic [Q_LVL_W-1:0]   r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_item  = r_mem[r_rptr];
    assign o_level = r_level;

endmodule

@@ design/rcc_back.sv @@
// Back end: applies the kernel to each queued window and holds the result word.
`timescale 1ns / 1ps

module rcc_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  rcc_pkg::t_win_item       i_q_item,
    output logic                     o_q_pop,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic [rcc_pkg::CH_W-1:0] o_red,
    output logic [rcc_pkg::CH_W-1:0] o_green,
    output logic [rcc_pkg::CH_W-1:0] o_blue,
    output logic                     o_last
);
    import rcc_pkg::*;

    logic            r_valid;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;
    logic            r_last;

    // advance when the result register is free or being drained
    assign o_q_pop = i_q_valid && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_red   <= conv_channel(i_q_item.win, CH_RED);
            r_green <= conv_channel(i_q_item.win, CH_GREEN);
            r_blue  <= conv_channel(i_q_item.win, CH_BLUE);
            r_last  <= i_q_item.last;
        end
    end

    assign o_empty = !r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_last  = r_last;

endmodule

@@ design/rgb_conv3x3_valid_clamp_core.sv @@
// Top level of the streaming 3x3 RGB convolution core over the valid region.
//
//  channel   handshake          payload                                       
//  pixels    i_push / o_full    i_red_in, i_green_in, i_blue_in               
//  results   o_empty / i_pop    o_red_out, o_green_out, o_blue_out,           
//                               o_alpha_out, o_frame_last                     
//  config    i_cfg_we           i_cfg_index, i_cfg_data                       
//
// One pixel word is taken per clock while o_full is low; a completed window passes through
// the queue to the result register, and results drain at one per clock while windows wait.
// The line stores (one RAM word per column) are read as a pixel enters and written back
// in the next cycle; a 4-entry queue decouples the window stage from the kernel stage.
// o_full rises when the queue plus the word in the window stage would fill the queue,
// so a low i_pop only backs the pipe up. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps

module rgb_conv3x3_valid_clamp_core #(
    parameter int MAX_WIDTH = rcc_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [7:0]                     i_red_in,
    input  logic [7:0]                     i_green_in,
    input  logic [7:0]                     i_blue_in,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [7:0]                     o_red_out,
    output logic [7:0]                     o_green_out,
    output logic [7:0]                     o_blue_out,
    output logic [7:0]                     o_alpha_out,
    output logic                           o_frame_last,
    input  logic                           i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rcc_pkg::*;

    logic               q_push;
    t_win_item          q_in_item;
    logic               q_pop;
    logic               q_valid;
    t_win_item          q_head;
    logic [Q_LVL_W-1:0] q_level;

    rcc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_pixel     ({i_blue_in, i_green_in, i_red_in}),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_level   (q_level),
        .o_q_push    (q_push),
        .o_q_item    (q_in_item)
    );

    rcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_head),
        .o_level (q_level)
    );

    rcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_head),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_red     (o_red_out),
        .o_green   (o_green_out),
        .o_blue    (o_blue_out),
        .o_last    (o_frame_last)
    );

    assign o_alpha_out = ALPHA_OPAQUE;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && !q_pop && q_level == Q_LVL_W'(Q_DEPTH)))
        else $error("window queue overflow");

    a_full_when_queue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_level == Q_LVL_W'(Q_DEPTH)) |-> o_full)
        else $error("pixel accepted with no queue room");

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("kernel stage drained an empty queue");

    a_result_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !o_empty)
        else $error("result word lost after queue drain");

endmodule

@@ bench/conv3x3_pixel_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts the convolved pixel stream of the 3x3 core and compares each result word.
module conv3x3_pixel_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [7:0]                     i_red_in,
    input  logic [7:0]                     i_green_in,
    input  logic [7:0]                     i_blue_in,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [7:0]                     i_red_out,
    input  logic [7:0]                     i_green_out,
    input  logic [7:0]                     i_blue_out,
    input  logic [7:0]                     i_alpha_out,
    input  logic                           i_frame_last,
    input  logic                           i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_conv_pixel;

    t_conv_pixel                    expected_pixels[$];
    logic [rcc_pkg::IMG_W_BITS-1:0] width_reg;
    logic [rcc_pkg::IMG_H_BITS-1:0] height_reg;
    logic [rcc_pkg::PIX_W-1:0]      line_older [0:rcc_pkg::MAX_WIDTH_DEF-1];
    logic [rcc_pkg::PIX_W-1:0]      line_newer [0:rcc_pkg::MAX_WIDTH_DEF-1];
    rcc_pkg::t_window               taps;
    int                             col_pos;
    int                             row_pos;
    int                             fail_total = 0;

    // kernel scaled by 4, first index column offset, second row offset
    function automatic int tap_weight(input int col, input int row);
        case (col * 3 + row)
            0: return 4;
            1: return 8;
            2: return -4;
            3: return 8;
            4: return 1;
            5: return -8;
            6: return 4;
            7: return -8;
            default: return -4;
        endcase
    endfunction

    function automatic logic [7:0] filter_channel(input rcc_pkg::t_window win, input int ch);
        int acc;
        int px;
        int q;
        acc = 0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                px  = int'(win[c][r][8*ch +: 8]);
                acc = acc + tap_weight(c, r) * px;
            end
        end
        if (acc < 0) return 8'h00;
        q = acc / 4;
        if (q > 255) return 8'hFF;
        return q[7:0];
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    task automatic compare_result();
        t_conv_pixel want;
        if (expected_pixels.size() == 0) begin
            $error("result word with no pending expectation");
            fail_total++;
        end else begin
            want = expected_pixels.pop_front();
            check_field("red_out", want.red, i_red_out);
            check_field("green_out", want.green, i_green_out);
            check_field("blue_out", want.blue, i_blue_out);
            check_field("alpha_out", want.alpha, i_alpha_out);
            check_field("frame_last", {7'd0, want.last}, {7'd0, i_frame_last});
        end
    endtask

    task automatic convolve_pixel(input logic [rcc_pkg::PIX_W-1:0] pix);
        int          w;
        int          h;
        int          col;
        int          row;
        t_conv_pixel res;
        w = width_reg;
        h = height_reg;
        if (w < 3) w = 3;
        if (w > rcc_pkg::MAX_WIDTH_DEF) w = rcc_pkg::MAX_WIDTH_DEF;
        if (h < 3) h = 3;
        if (h > rcc_pkg::MAX_HEIGHT) h = rcc_pkg::MAX_HEIGHT;
        col = (col_pos >= w) ? 0 : col_pos;
        row = (row_pos >= h) ? 0 : row_pos;
        // shift the window one column and load the new column from the line stores
        taps[0] = taps[1];
        taps[1] = taps[2];
        taps[2][0] = line_older[col];
        taps[2][1] = line_newer[col];
        taps[2][2] = pix;
        line_older[col] = line_newer[col];
        line_newer[col] = pix;
        if (row >= 2 && col >= 2) begin
            res.red   = filter_channel(taps, 0);
            res.green = filter_channel(taps, 1);
            res.blue  = filter_channel(taps, 2);
            res.alpha = rcc_pkg::ALPHA_OPAQUE;
            res.last  = (col == w - 1) && (row == h - 1);
            expected_pixels.push_back(res);
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        col_pos = col;
        row_pos = row;
    endtask

    task automatic apply_config();
        if (i_cfg_index == rcc_pkg::REG_IMAGE_WIDTH) begin
            width_reg = i_cfg_data[rcc_pkg::IMG_W_BITS-1:0];
            col_pos   = 0;
            row_pos   = 0;
        end else if (i_cfg_index == rcc_pkg::REG_IMAGE_HEIGHT) begin
            height_reg = i_cfg_data[rcc_pkg::IMG_H_BITS-1:0];
            col_pos    = 0;
            row_pos    = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = rcc_pkg::IMAGE_WIDTH_RST;
            height_reg = rcc_pkg::IMAGE_HEIGHT_RST;
            col_pos    = 0;
            row_pos    = 0;
            expected_pixels.delete();
        end else begin
            if (i_pop && !i_empty) compare_result();
            if (i_push && !i_full) convolve_pixel({i_blue_in, i_green_in, i_red_in});
            if (i_cfg_we) apply_config();
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ bench/tb_rgb_conv3x3_valid_clamp_core.sv @@
`timescale 1ns / 1ps
// Testbench top for the 3x3 convolution core: stimulus, idle patterns and the verdict.
module tb_rgb_conv3x3_valid_clamp_core;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLDOFF      = 8;

    localparam logic [rcc_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [rcc_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    // raster positions of a 3x3 frame used by the directed patterns (bit k for pixel k)
    localparam logic [8:0] POS_TAP = 9'h05B;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           push      = 1'b0;
    logic                           full;
    logic [7:0]                     red_in    = 8'd0;
    logic [7:0]                     green_in  = 8'd0;
    logic [7:0]                     blue_in   = 8'd0;
    logic                           empty;
    logic                           pop       = 1'b0;
    logic [7:0]                     red_out;
    logic [7:0]                     green_out;
    logic [7:0]                     blue_out;
    logic [7:0]                     alpha_out;
    logic                           frame_last;
    logic                           cfg_we    = 1'b0;
    logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rcc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int pending;
    int fail_count;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rgb_conv3x3_valid_clamp_core u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_red_in     (red_in),
        .i_green_in   (green_in),
        .i_blue_in    (blue_in),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_red_out    (red_out),
        .o_green_out  (green_out),
        .o_blue_out   (blue_out),
        .o_alpha_out  (alpha_out),
        .o_frame_last (frame_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    conv3x3_pixel_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_red_in     (red_in),
        .i_green_in   (green_in),
        .i_blue_in    (blue_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_red_out    (red_out),
        .i_green_out  (green_out),
        .i_blue_out   (blue_out),
        .i_alpha_out  (alpha_out),
        .i_frame_last (frame_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic set_idle(input int mode);
        case (mode)
            1: begin
                send_idle_pct = 54;
                recv_stall_pct <= 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct <= 54;
            end
            3: begin
                send_idle_pct = 35;
                recv_stall_pct <= 35;
            end
            default: begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
        endcase
    endtask

    // hold the word until accepted, then maybe idle for a random gap
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        push     <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            push     <= 1'b0;
            red_in   <= 8'($urandom);
            green_in <= 8'($urandom);
            blue_in  <= 8'($urandom);
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
    endtask

    task automatic drain_results(input int holdoff);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (holdoff) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_directed();
        set_idle(0);
        write_reg(rcc_pkg::REG_IMAGE_WIDTH, 13'd3);
        write_reg(rcc_pkg::REG_IMAGE_HEIGHT, 13'd3);
        // red saturates high, green clamps to zero
        for (int k = 0; k < 9; k++) begin
            send_pixel(POS_TAP[k] ? 8'hFF : 8'h00, POS_TAP[k] ? 8'h00 : 8'hFF, 8'($urandom));
        end
        drain_results(0);
        // flat red frame, zero green, small blue sum
        for (int k = 0; k < 9; k++) begin
            send_pixel(8'hFF, 8'h00, POS_TAP[k] ? 8'h01 : 8'h00);
        end
        // an unused register index must not restart the frame
        for (int k = 0; k < 3; k++) send_pixel(random_channel(), random_channel(), random_channel());
        drain_results(HOLDOFF);
        write_reg(REG_UNUSED_A, 13'h1FFF);
        for (int k = 3; k < 9; k++) send_pixel(random_channel(), random_channel(), random_channel());
    endtask

    task automatic run_phase(input logic [12:0] w_data, input logic [12:0] h_data,
                             input int n_pix, input int mode);
        int pause_at;
        int odd_at;
        pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_pix - 1) : -1;
        odd_at   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n_pix - 1) : -1;
        set_idle(mode);
        drain_results(HOLDOFF);
        write_reg(rcc_pkg::REG_IMAGE_WIDTH, w_data);
        write_reg(rcc_pkg::REG_IMAGE_HEIGHT, h_data);
        for (int k = 0; k < n_pix; k++) begin
            if (k == pause_at) drain_results(0);
            if (k == odd_at) begin
                drain_results(HOLDOFF);
                write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, 13'($urandom));
            end
            send_pixel(random_channel(), random_channel(), random_channel());
        end
    endtask

    initial begin
        int          phase;
        int          sent;
        int          n;
        int          ew;
        int          eh;
        logic [12:0] w_data;
        logic [12:0] h_data;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            w_data = 13'($urandom_range(0, 14));
            h_data = 13'($urandom_range(0, 7));
            ew     = (w_data < 3) ? 3 : w_data;
            eh     = (h_data < 3) ? 3 : h_data;
            n      = ew * eh * $urandom_range(1, 2) + $urandom_range(0, 2 * ew);
            run_phase(w_data, h_data, n, phase % 4);
            sent  = sent + n;
            phase = phase + 1;
        end
        // register values beyond the frame limits; no word is due this early in the frame
        run_phase(13'h1FFF, 13'h1FFF, 40, 3);
        drain_results(0);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
